FILE: sv/cesd_pkg.sv
// Shared types and constants for the C escape sequence decoder.
`default_nettype none

package cesd_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_THREE     = 8'h33;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_XSTART = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT    = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] value;
        logic [1:0] octs;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_state     next_state;
    } t_decode;

endpackage

`default_nettype wire

FILE: sv/cesd_in_if.sv
// Input channel: one escaped source byte per transaction.
`default_nettype none

interface cesd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_last;

    modport source (output valid, output in_byte, output string_last, input ready);
    modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

`default_nettype wire

FILE: sv/cesd_out_if.sv
// Output channel: one unescaped result per transaction.
`default_nettype none

interface cesd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_valid,
                    output string_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input string_end, input run_last, output ready);
endinterface

`default_nettype wire

FILE: sv/cesd_decode.sv
// Escape decode of one byte against the current state: up to two results and the next state.
`default_nettype none

module cesd_decode (
    input  var cesd_pkg::t_state  i_state,
    input  var logic [7:0]        i_byte,
    input  var logic              i_last,
    output var cesd_pkg::t_decode o_dec
);

    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_oct;
    logic       is_oct_lead;
    logic [7:0] simple_val;

    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= cesd_pkg::CH_ZERO && i_byte <= cesd_pkg::CH_NINE) begin
            hex_val = i_byte[3:0];
        end else if (i_byte >= cesd_pkg::CH_LC_A && i_byte <= cesd_pkg::CH_LC_F) begin
            hex_val = 4'(i_byte - cesd_pkg::CH_LC_A + 8'd10);
        end else if (i_byte >= cesd_pkg::CH_UC_A && i_byte <= cesd_pkg::CH_UC_F) begin
            hex_val = 4'(i_byte - cesd_pkg::CH_UC_A + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign is_oct      = (i_byte >= cesd_pkg::CH_ZERO) && (i_byte <= cesd_pkg::CH_SEVEN);
    assign is_oct_lead = (i_byte >= cesd_pkg::CH_ZERO) && (i_byte <= cesd_pkg::CH_THREE);

    always_comb begin
        unique case (i_byte)
            8'h61:   simple_val = 8'h07;
            8'h62:   simple_val = 8'h08;
            8'h74:   simple_val = 8'h09;
            8'h6E:   simple_val = 8'h0A;
            8'h76:   simple_val = 8'h0B;
            8'h66:   simple_val = 8'h0C;
            8'h72:   simple_val = 8'h0D;
            8'h3F:   simple_val = 8'h3F;
            default: simple_val = i_byte;
        endcase
    end

    always_comb begin
        logic [1:0]       n;
        cesd_pkg::t_result r0;
        cesd_pkg::t_result r1;
        cesd_pkg::t_state  nxt;
        logic             do_plain;
        logic             emit_a;
        logic [7:0]       val_a;
        logic [1:0]       octs_inc;

        n        = 2'd0;
        r0       = '0;
        r1       = '0;
        nxt      = i_state;
        do_plain = 1'b0;
        emit_a   = 1'b0;
        val_a    = 8'd0;
        octs_inc = 2'(i_state.octs + 2'd1);

        unique case (i_state.mode)
            cesd_pkg::MODE_ESC: begin
                if (i_byte == cesd_pkg::CH_X) begin
                    nxt.mode  = cesd_pkg::MODE_XSTART;
                    nxt.value = 8'd0;
                end else if (is_oct_lead) begin
                    nxt.mode  = cesd_pkg::MODE_OCT;
                    nxt.value = i_byte & 8'h07;
                    nxt.octs  = 2'd1;
                end else begin
                    nxt.mode = cesd_pkg::MODE_NORMAL;
                    emit_a   = 1'b1;
                    val_a    = simple_val;
                end
            end
            cesd_pkg::MODE_XSTART: begin
                if (is_hex) begin
                    nxt.mode  = cesd_pkg::MODE_HEX;
                    nxt.value = {4'd0, hex_val};
                end else begin
                    nxt.mode = cesd_pkg::MODE_NORMAL;
                    do_plain = 1'b1;
                end
            end
            cesd_pkg::MODE_HEX: begin
                if (is_hex) begin
                    nxt.value = {i_state.value[3:0], hex_val};
                end else begin
                    nxt.mode  = cesd_pkg::MODE_NORMAL;
                    emit_a    = 1'b1;
                    val_a     = i_state.value;
                    nxt.value = 8'd0;
                    do_plain  = 1'b1;
                end
            end
            cesd_pkg::MODE_OCT: begin
                if (is_oct) begin
                    nxt.value = {i_state.value[4:0], i_byte[2:0]};
                    nxt.octs  = octs_inc;
                    if (octs_inc == 2'd3) begin
                        emit_a    = 1'b1;
                        val_a     = {i_state.value[4:0], i_byte[2:0]};
                        nxt.mode  = cesd_pkg::MODE_NORMAL;
                        nxt.value = 8'd0;
                        nxt.octs  = 2'd0;
                    end
                end else begin
                    nxt.mode  = cesd_pkg::MODE_NORMAL;
                    emit_a    = 1'b1;
                    val_a     = i_state.value;
                    nxt.value = 8'd0;
                    nxt.octs  = 2'd0;
                    do_plain  = 1'b1;
                end
            end
            default: begin
                nxt.mode = cesd_pkg::MODE_NORMAL;
                do_plain = 1'b1;
            end
        endcase

        if (emit_a) begin
            r0.out_byte   = val_a;
            r0.byte_valid = 1'b1;
            n             = 2'd1;
        end

        if (do_plain) begin
            if (i_byte == cesd_pkg::CH_BACKSLASH) begin
                nxt.mode = cesd_pkg::MODE_ESC;
            end else if (n == 2'd0) begin
                r0.out_byte   = i_byte;
                r0.byte_valid = 1'b1;
                n             = 2'd1;
            end else begin
                r1.out_byte   = i_byte;
                r1.byte_valid = 1'b1;
                n             = 2'd2;
            end
        end

        if (i_last) begin
            // flush a pending numeric escape, or mark an empty end
            if (nxt.mode == cesd_pkg::MODE_HEX || nxt.mode == cesd_pkg::MODE_OCT) begin
                if (n == 2'd0) begin
                    r0.out_byte   = nxt.value;
                    r0.byte_valid = 1'b1;
                    n             = 2'd1;
                end else begin
                    r1.out_byte   = nxt.value;
                    r1.byte_valid = 1'b1;
                    n             = 2'd2;
                end
            end
            if (n == 2'd0) begin
                n = 2'd1;
            end
            nxt = '{mode: cesd_pkg::MODE_NORMAL, value: 8'd0, octs: 2'd0};
        end

        if (n == 2'd2) begin
            r1.run_last   = 1'b1;
            r1.string_end = i_last;
        end else begin
            r0.run_last   = 1'b1;
            r0.string_end = i_last;
        end

        o_dec.count      = n;
        o_dec.res0       = r0;
        o_dec.res1       = r1;
        o_dec.next_state = nxt;
    end

endmodule

`default_nettype wire

FILE: sv/c_escape_sequence_decoder_top.sv
// Top level of the C escape sequence decoder: input register, decode and two-slot result buffer.
// Takes one escaped byte per cycle and gives one unescaped result per cycle while the output
// side is ready. An input byte is held in the input register, is decoded against the escape
// state, and its results (none, one or two) land in a two-slot result buffer, so a result is
// offered from the result buffer once its byte has passed the input register. The buffer drains
// one entry per cycle, so a byte that flushes a pending escape and also gives a byte of its own
// holds the next byte back; otherwise the input is taken every cycle while the output keeps up.
`default_nettype none

module c_escape_sequence_decoder_top (
    input  var logic i_clk,
    input  var logic i_rst_n,
    cesd_in_if.sink    i_in,
    cesd_out_if.source o_out
);

    cesd_pkg::t_state  r_state;
    cesd_pkg::t_decode dec;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    cesd_pkg::t_result r_res0;
    cesd_pkg::t_result r_res1;
    logic [1:0]        r_cnt;

    logic              pop;
    logic              load;

    cesd_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_dec   (dec)
    );

    assign pop  = (r_cnt != 2'd0) && o_out.ready;
    assign load = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));

    assign i_in.ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.string_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: cesd_pkg::MODE_NORMAL, value: 8'd0, octs: 2'd0};
        end else if (load) begin
            r_state <= dec.next_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= dec.count;
        end else if (pop) begin
            r_cnt <= (r_cnt == 2'd2) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res0 <= dec.res0;
            r_res1 <= dec.res1;
        end else if (pop && (r_cnt == 2'd2)) begin
            r_res0 <= r_res1;
        end
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_byte   = r_res0.out_byte;
    assign o_out.byte_valid = r_res0.byte_valid;
    assign o_out.string_end = r_res0.string_end;
    assign o_out.run_last   = r_res0.run_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_cnt == 2'd2)) |=> (r_cnt == 2'd1) && (r_res0 == $past(r_res1)))
        else $error("second result not moved to head");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> o_out.run_last)
        else $error("string end without run_last");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |-> (o_out.string_end && (o_out.out_byte == 8'd0)))
        else $error("empty result that is not an end marker");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_last) |=> (r_state.mode == cesd_pkg::MODE_NORMAL))
        else $error("escape state not cleared at string end");

endmodule

`default_nettype wire
